// ----- rtl/hsvrgb_pkg.sv -----
// Package for the HSV to RGB converter: fixed-point formats, hue scaling
// constants and channel offsets. No dependencies.
package hsvrgb_pkg;

  // Field widths of the request and result channels
  localparam int HUE_W = 15;
  localparam int IN_W  = 8;
  localparam int OUT_W = 8;

  // Default channel resolution (full scale = 2^bits - 1)
  localparam int CHANNEL_BITS_DEF = 8;

  // Sector position and weight format: 12 fraction bits
  localparam int          FRAC_BITS = 12;
  localparam int unsigned ONE_FIX   = 4096;
  localparam int unsigned FOUR_FIX  = 4 * ONE_FIX;
  localparam int unsigned SIX_FIX   = 6 * ONE_FIX;

  // hpos = hue + floor(hue / 15); floor(hue / 15) = (hue * 34953) >> 19
  // is exact for every 15-bit hue.
  localparam int          HUE_PROD_W  = 31;
  localparam int unsigned DIV15_MULT  = 34953;
  localparam int          DIV15_SHIFT = 19;
  localparam int          HPOS_W      = 16;

  // hpos plus the channel offset, reduced sector position, weight
  localparam int SUM_W = HPOS_W + 1;
  localparam int K_W   = 15;
  localparam int F_W   = FRAC_BITS + 1;
  localparam int OFS_W = 3;

  // Channels and their sector offsets
  localparam int NUM_CH   = 3;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam logic [OFS_W-1:0] RED_OFFSET   = 3'd5;
  localparam logic [OFS_W-1:0] GREEN_OFFSET = 3'd3;
  localparam logic [OFS_W-1:0] BLUE_OFFSET  = 3'd1;

  // Pipeline depth
  localparam int NUM_STAGES = 5;

endpackage

// ----- rtl/hsvrgb_if.sv -----
// Valid/ready channel interfaces for the HSV request and the RGB result.
// Depends on hsvrgb_pkg for the field widths.
interface hsvrgb_hsv_if;
  logic                          valid;
  logic                          ready;
  logic [hsvrgb_pkg::HUE_W-1:0]  hue;
  logic [hsvrgb_pkg::IN_W-1:0]   saturation;
  logic [hsvrgb_pkg::IN_W-1:0]   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvrgb_rgb_if;
  logic                          valid;
  logic                          ready;
  logic [hsvrgb_pkg::OUT_W-1:0]  red;
  logic [hsvrgb_pkg::OUT_W-1:0]  green;
  logic [hsvrgb_pkg::OUT_W-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/hsv_to_rgb_converter_core.sv -----
// HSV to RGB converter: five register stages, one color per clock sustained
// while the result side is ready. Stage 1 scales hue by a reciprocal
// multiply, stage 2 forms the three sector weights and value*saturation,
// stage 3 multiplies by the weights, stage 4 adds the rounding half, stage 5
// divides by full scale and subtracts; the last stage is the output register.
// A stall on the result side holds each full stage in place while empty
// stages keep filling. Depends on hsvrgb_pkg, hsvrgb_if, hsvrgb_hue,
// hsvrgb_weight and hsvrgb_round.
module hsv_to_rgb_converter_core #(
  parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  hsvrgb_hsv_if.sink          hsv_i,
  hsvrgb_rgb_if.source        rgb_o
);

  localparam int CB  = CHANNEL_BITS;
  localparam int VW  = 2 * CB;
  localparam int FW  = hsvrgb_pkg::F_W;
  localparam int PW  = VW + FW;
  localparam int NS  = hsvrgb_pkg::NUM_STAGES;
  localparam int NCH = hsvrgb_pkg::NUM_CH;
  localparam int FB  = hsvrgb_pkg::FRAC_BITS;

  // Half of the divisor full * 4096, for round to nearest
  localparam logic [PW-1:0] HALF_D = PW'(64'((64'(1) << CB) - 64'(1)) << (FB - 1));

  // Pipeline control
  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_d;
  logic [NS:0]   rdy;

  // Stage payloads
  logic [hsvrgb_pkg::HPOS_W-1:0] hpos_d;
  logic [hsvrgb_pkg::HPOS_W-1:0] hpos_q;
  logic [CB-1:0]                 sat1_q;
  logic [CB-1:0]                 val1_q;
  logic [FW-1:0]                 f_d [NCH];
  logic [FW-1:0]                 f_q [NCH];
  logic [VW-1:0]                 vs_q;
  logic [CB-1:0]                 val2_q;
  logic [PW-1:0]                 p_q [NCH];
  logic [CB-1:0]                 val3_q;
  logic [PW-1:0]                 n_sum [NCH];
  logic [VW-1:0]                 m_d [NCH];
  logic [VW-1:0]                 m_q [NCH];
  logic [CB-1:0]                 val4_q;
  logic [CB-1:0]                 chan_d [NCH];
  logic [CB-1:0]                 chan_q [NCH];

  // A stage may load when it is empty or the next one moves on
  always_comb begin
    rdy[NS] = rgb_o.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = ~vld_q[i] | rdy[i+1];
    end
  end

  always_comb begin
    vld_d[0] = rdy[0] ? hsv_i.valid : vld_q[0];
    for (int i = 1; i < NS; i++) begin
      vld_d[i] = rdy[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign hsv_i.ready = rdy[0];

  // Stage 1: hue scaling
  hsvrgb_hue u_hue (
    .hue_i  (hsv_i.hue),
    .hpos_o (hpos_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      hpos_q <= hpos_d;
      sat1_q <= CB'(hsv_i.saturation);
      val1_q <= CB'(hsv_i.brightness);
    end
  end

  // Stage 2: sector weights and value * saturation
  hsvrgb_weight u_weight_red (
    .hpos_i   (hpos_q),
    .offset_i (hsvrgb_pkg::RED_OFFSET),
    .weight_o (f_d[hsvrgb_pkg::CH_RED])
  );

  hsvrgb_weight u_weight_green (
    .hpos_i   (hpos_q),
    .offset_i (hsvrgb_pkg::GREEN_OFFSET),
    .weight_o (f_d[hsvrgb_pkg::CH_GREEN])
  );

  hsvrgb_weight u_weight_blue (
    .hpos_i   (hpos_q),
    .offset_i (hsvrgb_pkg::BLUE_OFFSET),
    .weight_o (f_d[hsvrgb_pkg::CH_BLUE])
  );

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int i = 0; i < NCH; i++) begin
        f_q[i] <= f_d[i];
      end
      vs_q   <= VW'(sat1_q) * VW'(val1_q);
      val2_q <= val1_q;
    end
  end

  // Stage 3: weight the product
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int i = 0; i < NCH; i++) begin
        p_q[i] <= PW'(vs_q) * PW'(f_q[i]);
      end
      val3_q <= val2_q;
    end
  end

  // Stage 4: add half the divisor, drop the fraction bits
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      n_sum[i] = p_q[i] + HALF_D;
      m_d[i]   = n_sum[i][FB+VW-1:FB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int i = 0; i < NCH; i++) begin
        m_q[i] <= m_d[i];
      end
      val4_q <= val3_q;
    end
  end

  // Stage 5: divide by full scale and subtract, into the output register
  for (genvar g = 0; g < NCH; g++) begin : g_round
    hsvrgb_round #(
      .CHANNEL_BITS (CHANNEL_BITS)
    ) u_round (
      .quot_i (m_q[g]),
      .val_i  (val4_q),
      .chan_o (chan_d[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int i = 0; i < NCH; i++) begin
        chan_q[i] <= chan_d[i];
      end
    end
  end

  // Result channel
  assign rgb_o.valid = vld_q[NS-1];
  assign rgb_o.red   = hsvrgb_pkg::OUT_W'(chan_q[hsvrgb_pkg::CH_RED]);
  assign rgb_o.green = hsvrgb_pkg::OUT_W'(chan_q[hsvrgb_pkg::CH_GREEN]);
  assign rgb_o.blue  = hsvrgb_pkg::OUT_W'(chan_q[hsvrgb_pkg::CH_BLUE]);

endmodule

// ----- rtl/hsvrgb_weight.sv -----
// Per-channel sector weight: k = (hpos + n) mod 6, f = clamp(min(k, 4-k), 0, 1).
// Depends on hsvrgb_pkg for the fixed-point constants.
module hsvrgb_weight (
  input  logic [hsvrgb_pkg::HPOS_W-1:0] hpos_i,
  input  logic [hsvrgb_pkg::OFS_W-1:0]  offset_i,
  output logic [hsvrgb_pkg::F_W-1:0]    weight_o
);

  localparam int SW = hsvrgb_pkg::SUM_W;
  localparam int KW = hsvrgb_pkg::K_W;

  localparam logic [SW-1:0] SIX_S    = SW'(hsvrgb_pkg::SIX_FIX);
  localparam logic [SW-1:0] TWELVE_S = SW'(2 * hsvrgb_pkg::SIX_FIX);
  localparam logic [KW-1:0] FOUR_K   = KW'(hsvrgb_pkg::FOUR_FIX);
  localparam logic [KW-1:0] ONE_K    = KW'(hsvrgb_pkg::ONE_FIX);

  logic [SW-1:0] pos_sum;
  logic [KW-1:0] sector;
  logic [KW-1:0] rise;
  logic [KW-1:0] fall;
  logic [KW-1:0] tri_val;

  // Add the offset, then wrap into 0..6 (never more than two turns)
  assign pos_sum = SW'(hpos_i) + (SW'(offset_i) << hsvrgb_pkg::FRAC_BITS);

  always_comb begin
    if (pos_sum >= TWELVE_S) begin
      sector = KW'(pos_sum - TWELVE_S);
    end else if (pos_sum >= SIX_S) begin
      sector = KW'(pos_sum - SIX_S);
    end else begin
      sector = KW'(pos_sum);
    end
  end

  // Triangle min(k, 4-k), zero beyond 4, limited to 1.0
  always_comb begin
    rise = sector;
    fall = FOUR_K - sector;
    if (sector >= FOUR_K) begin
      tri_val = '0;
    end else if (rise < fall) begin
      tri_val = rise;
    end else begin
      tri_val = fall;
    end
    if (tri_val > ONE_K) begin
      weight_o = hsvrgb_pkg::F_W'(ONE_K);
    end else begin
      weight_o = hsvrgb_pkg::F_W'(tri_val);
    end
  end

endmodule

// ----- rtl/hsvrgb_round.sv -----
// Final channel step: divide the scaled product by full scale and subtract
// from value. Depends on hsvrgb_pkg for the default resolution.
module hsvrgb_round #(
  parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic [2*CHANNEL_BITS-1:0] quot_i,
  input  logic [CHANNEL_BITS-1:0]   val_i,
  output logic [CHANNEL_BITS-1:0]   chan_o
);

  localparam int CB = CHANNEL_BITS;
  localparam int SW = 2 * CB + 1;

  logic [SW-1:0] div_sum;
  logic [CB-1:0] term;

  // floor(x / (2^CB - 1)) = (x + 1 + (x >> CB)) >> CB, exact for x below
  // full * 2^CB, which the rounded product always is.
  assign div_sum = SW'(quot_i) + SW'(1) + SW'(quot_i >> CB);
  assign term    = div_sum[2*CB-1:CB];

  // Channel = value - term, never below zero
  assign chan_o = (term > val_i) ? '0 : val_i - term;

endmodule

// ----- rtl/hsvrgb_to_rgb_top_placeholder.sv -----
// Hue front end: hpos = floor(hue * 16 / 15) through a reciprocal multiply.
// Depends on hsvrgb_pkg for the scaling constants.
module hsvrgb_hue (
  input  logic [hsvrgb_pkg::HUE_W-1:0]  hue_i,
  output logic [hsvrgb_pkg::HPOS_W-1:0] hpos_o
);

  localparam int PW = hsvrgb_pkg::HUE_PROD_W;

  logic [PW-1:0] hue_prod;

  // floor(hue / 15) via multiply by 2^19/15 rounded up
  assign hue_prod = PW'(hue_i) * PW'(hsvrgb_pkg::DIV15_MULT);
  assign hpos_o   = hsvrgb_pkg::HPOS_W'(hue_i)
                  + hsvrgb_pkg::HPOS_W'(hue_prod[PW-1:hsvrgb_pkg::DIV15_SHIFT]);

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for hsv_to_rgb_converter_core: directed table, then random colors,
// checked against typed values or a local fixed-point predictor. Depends on hsvrgb_pkg, hsvrgb_if
// and the converter RTL.
module testbench;
  import hsvrgb_pkg::*;

  localparam int              CH_BITS     = CHANNEL_BITS_DEF;
  localparam longint unsigned FULL_SCALE  = (64'd1 << CH_BITS) - 1;
  localparam int              STALL_LIMIT = 1000;
  localparam int              PHASE_ITEMS = 430;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [IN_W-1:0]  sat;
    logic [IN_W-1:0]  bri;
  } hsv_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } rgb_t;

  typedef struct {
    hsv_req_t req;
    bit       typed;
    rgb_t     want;
  } color_row_t;

  bit   clk_i;
  logic rst_ni;

  hsvrgb_hsv_if hsv_bus ();
  hsvrgb_rgb_if rgb_bus ();

  hsv_to_rgb_converter_core #(
    .CHANNEL_BITS(CH_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .hsv_i (hsv_bus),
    .rgb_o (rgb_bus)
  );

  rgb_t       rgb_expected_q[$];
  color_row_t color_rows[$];
  int         fail_count   = 0;
  int         stall_cycles = 0;
  int         src_idle_pct = 33;
  int         snk_idle_pct = 73;

  // Clock
  initial begin
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  // One channel: k = (hpos + n) mod 6, weight = clamp(min(k, 4 - k), 0, 1)
  function automatic logic [OUT_W-1:0] channel_level(input int unsigned hpos,
                                                     input int unsigned ofs,
                                                     input longint unsigned s,
                                                     input longint unsigned v);
    int unsigned     k;
    int unsigned     f;
    longint unsigned den;
    longint unsigned term;
    den = FULL_SCALE * ONE_FIX;
    k   = (hpos + ofs * ONE_FIX) % SIX_FIX;
    if (k >= FOUR_FIX) begin
      f = 0;
    end else begin
      f = (k < FOUR_FIX - k) ? k : FOUR_FIX - k;
    end
    if (f > ONE_FIX) f = ONE_FIX;
    term = (den != 0) ? (v * s * f + den / 2) / den : 0;
    if (term > v) term = v;
    return OUT_W'((v - term) & FULL_SCALE);
  endfunction

  function automatic rgb_t hsv_to_rgb_predict(input hsv_req_t req);
    int unsigned     hpos;
    longint unsigned s;
    longint unsigned v;
    rgb_t            res;
    hpos      = (int'(req.hue) * 16) / 15;
    s         = longint'(req.sat) & FULL_SCALE;
    v         = longint'(req.bri) & FULL_SCALE;
    res.red   = channel_level(hpos, RED_OFFSET, s, v);
    res.green = channel_level(hpos, GREEN_OFFSET, s, v);
    res.blue  = channel_level(hpos, BLUE_OFFSET, s, v);
    return res;
  endfunction

  function automatic void add_row(input int h, input int s, input int v, input bit typed = 0,
                                  input int r = 0, input int g = 0, input int b = 0);
    color_row_t row;
    row.req.hue    = HUE_W'(h);
    row.req.sat    = IN_W'(s);
    row.req.bri    = IN_W'(v);
    row.typed      = typed;
    row.want.red   = OUT_W'(r);
    row.want.green = OUT_W'(g);
    row.want.blue  = OUT_W'(b);
    color_rows.push_back(row);
  endfunction

  // Random color: mostly in-range hue, some near sector edges, some anywhere in 15 bits
  function automatic logic [IN_W-1:0] random_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return IN_W'($urandom_range(255));
    endcase
  endfunction

  function automatic hsv_req_t random_color();
    hsv_req_t req;
    int       h;
    case ($urandom_range(9))
      0, 1, 2, 3: h = int'($urandom_range(23040));
      4, 5: begin
        h = int'($urandom_range(6)) * 3840 + int'($urandom_range(4)) - 2;
        if (h < 0) h = 0;
      end
      default: h = int'($urandom_range(32767));
    endcase
    req.hue = HUE_W'(h);
    req.sat = random_level();
    req.bri = random_level();
    return req;
  endfunction

  function automatic void check_field(input string name, input logic [OUT_W-1:0] want,
                                      input logic [OUT_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Drive one request from a falling edge; returns at the falling edge after acceptance
  task automatic send_color(input hsv_req_t req, input rgb_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      hsv_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    hsv_bus.valid      <= 1'b1;
    hsv_bus.hue        <= req.hue;
    hsv_bus.saturation <= req.sat;
    hsv_bus.brightness <= req.bri;
    @(posedge clk_i);
    while (!hsv_bus.ready) @(posedge clk_i);
    rgb_expected_q.push_back(want);
    @(negedge clk_i);
  endtask

  // Hold off requests until every pending result is out
  task automatic wait_drained();
    hsv_bus.valid <= 1'b0;
    do @(negedge clk_i); while (rgb_expected_q.size() != 0);
  endtask

  // Result side back-pressure
  always @(negedge clk_i) begin
    rgb_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Result checker and stall watchdog
  always @(posedge clk_i) begin : result_monitor
    rgb_t got;
    rgb_t want;
    if (rgb_bus.valid && rgb_bus.ready) begin
      got.red   = rgb_bus.red;
      got.green = rgb_bus.green;
      got.blue  = rgb_bus.blue;
      if (rgb_expected_q.size() == 0) begin
        $error("result with no pending request: %0d %0d %0d", got.red, got.green, got.blue);
        fail_count++;
      end else begin
        want = rgb_expected_q.pop_front();
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
      end
    end
    if ((hsv_bus.valid && hsv_bus.ready) || (rgb_bus.valid && rgb_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int phase_src[3];
    int phase_snk[3];
    rgb_t want;
    hsv_req_t req;
    phase_src = '{33, 73, 0};
    phase_snk = '{73, 33, 0};
    rst_ni             <= 1'b0;
    hsv_bus.valid      <= 1'b0;
    hsv_bus.hue        <= '0;
    hsv_bus.saturation <= '0;
    hsv_bus.brightness <= '0;

    // Directed rows: primaries and secondaries, hue wrap, zero value and saturation, extremes
    add_row(0, 255, 255, 1, 255, 0, 0);
    add_row(0, 0, 0, 1, 0, 0, 0);
    add_row(0, 255, 0, 1, 0, 0, 0);
    add_row(32767, 255, 255);
    add_row(32767, 0, 255, 1, 255, 255, 255);
    add_row(23040, 255, 255, 1, 255, 0, 0);
    add_row(3840, 255, 255, 1, 255, 255, 0);
    add_row(7680, 255, 255, 1, 0, 255, 0);
    add_row(11520, 255, 255, 1, 0, 255, 255);
    add_row(15360, 255, 255, 1, 0, 0, 255);
    add_row(19200, 255, 255, 1, 255, 0, 255);
    add_row(1920, 255, 255);
    add_row(0, 128, 255);
    add_row(3839, 128, 200);
    add_row(3841, 200, 128);
    add_row(23039, 255, 255);
    add_row(23041, 255, 255);
    add_row(12345, 255, 128);
    add_row(5000, 1, 1);
    add_row(16384, 85, 170);
    add_row(21845, 170, 85);
    add_row(10922, 85, 170);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (color_rows[i]) begin
      want = color_rows[i].typed ? color_rows[i].want : hsv_to_rgb_predict(color_rows[i].req);
      send_color(color_rows[i].req, want);
    end

    // Random phases with different idle mixes; each opens with the pipeline drained
    for (int p = 0; p < 3; p++) begin
      wait_drained();
      src_idle_pct = phase_src[p];
      snk_idle_pct = phase_snk[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        req = random_color();
        send_color(req, hsv_to_rgb_predict(req));
        if ($urandom_range(99) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (NUM_STAGES + 4) @(posedge clk_i);
    if (fail_count == 0 && rgb_expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
